// ----- rtl/sld_pkg.sv -----
// Shared types and constants for the STA/LTA event detector.
// No dependencies.
`default_nettype none
package sld_pkg;
   localparam int SampleWidth = 16;
   localparam int FiltWidth   = 40;
   localparam int AvgWidth    = 34;
   localparam int CoefWidth   = 16;
   localparam int CsrAddrWidth = 5;

   localparam logic [AvgWidth-1:0] LtaMin = 34'd66;
   localparam logic [AvgWidth-1:0] MagMax = {AvgWidth{1'b1}};

   typedef enum logic [2:0] {
      CSR_HIGHPASS = 3'd0,
      CSR_SHORT    = 3'd1,
      CSR_LONG     = 3'd2,
      CSR_TRIGGER  = 3'd3,
      CSR_FOOT_HP  = 3'd4,
      CSR_FOOT_LP  = 3'd5,
      CSR_VEH_HP   = 3'd6,
      CSR_VEH_LP   = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      CLASS_UNKNOWN  = 2'd0,
      CLASS_FOOTSTEP = 2'd1,
      CLASS_VEHICLE  = 2'd2,
      CLASS_MULTIPLE = 2'd3
   } detect_class_type;

   // operation codes for the shared serial multiply unit
   typedef enum logic [2:0] {
      OP_HIGHPASS = 3'd0,  // floor((y + d*2^16) * (2^16 - a) / 2^16)
      OP_LOWPASS  = 3'd1,  // y + floor((x - y) * a / 2^16)
      OP_AVERAGE  = 3'd2,  // unsigned avg update
      OP_PRODUCT  = 3'd3   // plain product, no shift
   } mac_op_type;

   typedef struct packed {
      logic       start;
      mac_op_type op;
   } mac_ctrl_type;

   function automatic logic signed [FiltWidth-1:0] sat40(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = 64'sd549755813887;
      lo = -64'sd549755813888;
      if (v > hi) return hi[FiltWidth-1:0];
      if (v < lo) return lo[FiltWidth-1:0];
      return v[FiltWidth-1:0];
   endfunction

   function automatic logic [AvgWidth-1:0] rectify(input logic signed [FiltWidth-1:0] v);
      logic [FiltWidth-1:0] m;
      m = v[FiltWidth-1] ? FiltWidth'(-v) : FiltWidth'(v);
      if (m > FiltWidth'(MagMax)) return MagMax;
      return m[AvgWidth-1:0];
   endfunction
endpackage
`default_nettype wire

// ----- rtl/sld_stream_if.sv -----
// Valid/ready stream interface with a generic payload.
// Depends on nothing.
`default_nettype none
interface sld_stream_if #(parameter int Width = 16) (input wire logic clock);
   logic             valid;
   logic             ready;
   logic [Width-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- rtl/sld_serial_mac.sv -----
// Bit-serial signed multiplier: one multiplier bit per cycle, shift-and-add.
// Depends on sld_pkg. Computes a 64-bit signed product of a by an unsigned
// 17-bit factor b.
`default_nettype none
module sld_serial_mac (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic signed [47:0]  mult_a,
   input  wire logic [16:0]         mult_b,
   output logic                     done,
   output logic signed [63:0]       product
);
   import sld_pkg::*;

   logic signed [63:0] acc_ff, acc_in;
   logic signed [63:0] mcand_ff, mcand_in;
   logic [16:0]        mplier_ff, mplier_in;
   logic [4:0]         count_ff, count_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;

   always_comb begin
      acc_in = acc_ff;
      mcand_in = mcand_ff;
      mplier_in = mplier_ff;
      count_in = count_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in = '0;
         mcand_in = 64'(mult_a);
         mplier_in = mult_b;
         count_in = 5'd17;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // add one partial product, advance one bit
         if (mplier_ff[0]) acc_in = acc_ff + mcand_ff;
         mcand_in = mcand_ff <<< 1;
         mplier_in = mplier_ff >> 1;
         count_in = count_ff - 5'd1;
         if (count_ff == 5'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         count_ff <= count_in;
      end
      acc_ff <= acc_in;
      mcand_ff <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign done = done_ff;
   assign product = acc_ff;
endmodule
`default_nettype wire

// ----- rtl/sta_lta_event_detector_unit.sv -----
// STA/LTA vibration event detector, top level.
// Depends on sld_pkg, sld_stream_if and sld_serial_mac.
//
// Usage: samples enter on the req channel (16-bit signed payload), and each
// produces exactly one result transaction on the rsp channel, packed as
// {triggered, class code, confidence, peak level, noise_floor} (43 bits).
// Coefficients are written over the csr APB port at byte address 4*index;
// write them only while no sample is in flight.
// Operation: a sample runs ten products (nine while the long-term average is
// frozen) in turn on one shared bit-serial 17-bit multiplier, then a restoring
// divider for the confidence. One sample is processed at a time: a new sample
// is accepted only once the sequencer is back in its idle state.
// The result sits in an output register; the next sample is accepted while
// it waits, and its result waits until the receiver takes the previous one.
// Reset is synchronous and clears all filter state and restores the
// default coefficients.
`default_nettype none
module sta_lta_event_detector_unit #(
   parameter int HoldoffSamples = 500,
   parameter int EnergyCoef     = 262
) (
   input  wire logic             clock,
   input  wire logic             reset,
   sld_stream_if.sink            req,
   sld_stream_if.source          rsp,
   input  wire logic             csr_psel,
   input  wire logic             csr_penable,
   input  wire logic             csr_pwrite,
   input  wire logic [sld_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  wire logic [31:0]      csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);
   import sld_pkg::*;

   localparam logic [15:0] HoldLoad   = 16'(HoldoffSamples);
   localparam logic [16:0] EnergyC    = 17'(EnergyCoef);

   // ---------------- registers ----------------
   logic [15:0] coef_ff [8];
   logic [2:0]  csr_idx;
   assign csr_idx = csr_paddr[4:2];
   assign csr_pready = 1'b1;
   always_comb csr_prdata = {16'd0, coef_ff[csr_idx]};

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff[CSR_HIGHPASS] <= 16'd813;
         coef_ff[CSR_SHORT]    <= 16'd1311;
         coef_ff[CSR_LONG]     <= 16'd13;
         coef_ff[CSR_TRIGGER]  <= 16'd768;
         coef_ff[CSR_FOOT_HP]  <= 16'd13161;
         coef_ff[CSR_FOOT_LP]  <= 16'd32853;
         coef_ff[CSR_VEH_HP]   <= 16'd1607;
         coef_ff[CSR_VEH_LP]   <= 16'd13161;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[1:0] == 2'b00) begin
         coef_ff[csr_idx] <= csr_pwdata[15:0];
      end
   end

   // ---------------- sequencer ----------------
   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_ISSUE = 8'b0000_0010,
      ST_WAIT  = 8'b0000_0100,
      ST_DIV   = 8'b0000_1000,
      ST_DONE  = 8'b0001_0000
   } state_type;

   // step codes; each but K_DONE issues one product
   typedef enum logic [3:0] {
      K_HP_IN   = 4'd0,
      K_HP_FOOT = 4'd1,
      K_HP_VEH  = 4'd2,
      K_LP_FOOT = 4'd3,
      K_LP_VEH  = 4'd4,
      K_STA     = 4'd5,
      K_LTA     = 4'd6,
      K_EN_FOOT = 4'd7,
      K_EN_VEH  = 4'd8,
      K_TRIG    = 4'd9,
      K_DONE    = 4'd10
   } step_type;

   state_type state_ff, state_in;
   step_type  step_ff, step_in;

   logic signed [FiltWidth-1:0] hp_in_ff, hp_foot_ff, hp_veh_ff, lp_foot_ff, lp_veh_ff;
   logic signed [SampleWidth-1:0] prev_ff, x_ff;
   logic [AvgWidth-1:0] sta_ff, lta_ff, en_foot_ff, en_veh_ff, pk_foot_ff, pk_veh_ff;
   logic        in_event_ff;
   logic [15:0] hold_ff;
   logic        lta_upd_ff;

   // result register
   logic        out_valid_ff;
   logic [42:0] out_ff;
   logic        trig_ff;
   logic [1:0]  cls_ff;
   logic [15:0] pk_out_ff;

   // multiplier operand selection
   logic               m_start;
   logic signed [47:0] m_a;
   logic [16:0]        m_b;
   logic               m_done;
   logic signed [63:0] m_p;
   logic               m_neg; // average: r < avg

   sld_serial_mac u_mac (
      .clock(clock), .reset(reset), .start(m_start), .mult_a(m_a), .mult_b(m_b),
      .done(m_done), .product(m_p)
   );

   logic [AvgWidth-1:0] r_in, r_foot, r_veh;
   assign r_in   = rectify(hp_in_ff);
   assign r_foot = rectify(lp_foot_ff);
   assign r_veh  = rectify(lp_veh_ff);

   logic signed [FiltWidth+1:0] d_in;   // x - prev scaled, plus y
   logic [AvgWidth-1:0] avg_cur, avg_tgt;
   logic [16:0] avg_coef;

   always_comb begin
      avg_cur = sta_ff; avg_tgt = r_in; avg_coef = {1'b0, coef_ff[CSR_SHORT]};
      case (step_ff)
         K_LTA:     begin avg_cur = lta_ff;     avg_tgt = r_in;   avg_coef = {1'b0, coef_ff[CSR_LONG]}; end
         K_EN_FOOT: begin avg_cur = en_foot_ff; avg_tgt = r_foot; avg_coef = EnergyC; end
         K_EN_VEH:  begin avg_cur = en_veh_ff;  avg_tgt = r_veh;  avg_coef = EnergyC; end
         default:   begin avg_cur = sta_ff;     avg_tgt = r_in;   avg_coef = {1'b0, coef_ff[CSR_SHORT]}; end
      endcase
      m_neg = avg_tgt < avg_cur;
   end

   logic signed [16:0] dx;
   assign dx = 17'(x_ff) - 17'(prev_ff);

   always_comb begin
      m_a = '0; m_b = '0; d_in = '0;
      case (step_ff)
         K_HP_IN, K_HP_FOOT, K_HP_VEH: begin
            case (step_ff)
               K_HP_FOOT: begin d_in = 42'(hp_foot_ff) + (42'(dx) <<< 16);
                  m_b = 17'h10000 - 17'(coef_ff[CSR_FOOT_HP]); end
               K_HP_VEH:  begin d_in = 42'(hp_veh_ff) + (42'(dx) <<< 16);
                  m_b = 17'h10000 - 17'(coef_ff[CSR_VEH_HP]); end
               default:   begin d_in = 42'(hp_in_ff) + (42'(dx) <<< 16);
                  m_b = 17'h10000 - 17'(coef_ff[CSR_HIGHPASS]); end
            endcase
            m_a = 48'(d_in);
         end
         K_LP_FOOT: begin m_a = 48'(hp_foot_ff) - 48'(lp_foot_ff); m_b = {1'b0, coef_ff[CSR_FOOT_LP]}; end
         K_LP_VEH:  begin m_a = 48'(hp_veh_ff) - 48'(lp_veh_ff);   m_b = {1'b0, coef_ff[CSR_VEH_LP]}; end
         K_STA, K_LTA, K_EN_FOOT, K_EN_VEH: begin
            m_a = m_neg ? 48'(avg_cur - avg_tgt) : 48'(avg_tgt - avg_cur);
            m_b = avg_coef;
         end
         K_TRIG: begin m_a = 48'(lta_ff); m_b = {1'b0, coef_ff[CSR_TRIGGER]}; end
         default: begin m_a = '0; m_b = '0; end
      endcase
   end

   // floor of signed product by 2^16
   logic signed [63:0] p_floor;
   assign p_floor = m_p >>> 16;
   logic [63:0] p_ceil_u;
   assign p_ceil_u = (m_p + 64'sd65535) >>> 16;

   // ---------------- divider for confidence ----------------
   // conf = floor(sta*16384 / (lta*tr)), saturated at 255: 9 quotient bits suffice
   logic [63:0] den_ff;
   logic [63:0] rem_ff;
   logic [8:0]  quo_ff;
   logic [3:0]  dcnt_ff;
   logic [63:0] trial;
   assign trial = den_ff << dcnt_ff;

   logic [AvgWidth-1:0] peak_max;
   assign peak_max = (pk_foot_ff > pk_veh_ff) ? pk_foot_ff : pk_veh_ff;

   detect_class_type cls_pick;
   logic [15:0]      pk_pick;
   always_comb begin
      if ({1'b0, en_foot_ff} > {en_veh_ff, 1'b0}) cls_pick = CLASS_FOOTSTEP;
      else if ({1'b0, en_veh_ff} > {en_foot_ff, 1'b0}) cls_pick = CLASS_VEHICLE;
      else if (en_foot_ff != '0 || en_veh_ff != '0) cls_pick = CLASS_MULTIPLE;
      else cls_pick = CLASS_UNKNOWN;
   end
   assign pk_pick = (peak_max[AvgWidth-1:32] != '0) ? 16'hFFFF : peak_max[31:16];

   logic lta_ok;
   assign lta_ok = lta_ff >= LtaMin;

   assign req.ready = (state_ff == ST_IDLE);
   assign m_start = (state_ff == ST_ISSUE);

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      case (state_ff)
         ST_IDLE:  if (req.valid) begin state_in = ST_ISSUE; step_in = K_HP_IN; end
         ST_ISSUE: state_in = ST_WAIT;
         ST_WAIT:  if (m_done) begin
            if (step_ff == K_TRIG) begin
               state_in = ST_DIV;
            end else begin
               step_in = step_type'(step_ff + 4'd1);
               state_in = ST_ISSUE;
               // skip the long-term average while it is frozen
               if (step_ff == K_STA && !lta_upd_ff) step_in = K_EN_FOOT;
            end
         end
         ST_DIV:   if (dcnt_ff == 4'd0) state_in = ST_DONE;
         ST_DONE:  if (!out_valid_ff || rsp.ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   logic start_trig;
   logic [63:0] lhs256, lhs512, rhs;
   assign lhs256 = 64'(sta_ff) << 8;
   assign lhs512 = 64'(sta_ff) << 9;
   assign rhs = 64'(m_p);
   assign start_trig = !in_event_ff && lta_ok && (lhs256 >= rhs);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff <= K_HP_IN;
         hp_in_ff <= '0; hp_foot_ff <= '0; hp_veh_ff <= '0;
         lp_foot_ff <= '0; lp_veh_ff <= '0;
         prev_ff <= '0;
         sta_ff <= '0; lta_ff <= '0; en_foot_ff <= '0; en_veh_ff <= '0;
         pk_foot_ff <= '0; pk_veh_ff <= '0;
         in_event_ff <= 1'b0;
         hold_ff <= '0;
         lta_upd_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         trig_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         if (state_ff == ST_DONE && (!out_valid_ff || rsp.ready)) out_valid_ff <= 1'b1;
         else if (rsp.ready) out_valid_ff <= 1'b0;
         if (state_ff == ST_IDLE && req.valid) begin
            x_ff <= req.payload;
            lta_upd_ff <= !in_event_ff && hold_ff == 16'd0;
            if (hold_ff != 16'd0) hold_ff <= hold_ff - 16'd1;
         end
         if (state_ff == ST_WAIT && m_done) begin
            case (step_ff)
               K_HP_IN:   hp_in_ff <= sat40(p_floor);
               K_HP_FOOT: hp_foot_ff <= sat40(p_floor);
               K_HP_VEH:  hp_veh_ff <= sat40(p_floor);
               K_LP_FOOT: lp_foot_ff <= sat40(64'(lp_foot_ff) + p_floor);
               K_LP_VEH:  lp_veh_ff <= sat40(64'(lp_veh_ff) + p_floor);
               K_STA:     sta_ff <= m_neg ? sta_ff - AvgWidth'(p_ceil_u) : sta_ff + AvgWidth'(p_floor);
               K_LTA:     lta_ff <= m_neg ? lta_ff - AvgWidth'(p_ceil_u) : lta_ff + AvgWidth'(p_floor);
               K_EN_FOOT: begin
                  en_foot_ff <= m_neg ? en_foot_ff - AvgWidth'(p_ceil_u) : en_foot_ff + AvgWidth'(p_floor);
                  if (r_foot > pk_foot_ff) pk_foot_ff <= r_foot;
               end
               K_EN_VEH: begin
                  en_veh_ff <= m_neg ? en_veh_ff - AvgWidth'(p_ceil_u) : en_veh_ff + AvgWidth'(p_floor);
                  if (r_veh > pk_veh_ff) pk_veh_ff <= r_veh;
                  prev_ff <= x_ff;
               end
               K_TRIG: begin
                  trig_ff <= start_trig;
                  cls_ff <= start_trig ? cls_pick : CLASS_UNKNOWN;
                  pk_out_ff <= start_trig ? pk_pick : 16'd0;
                  den_ff <= rhs;
                  rem_ff <= 64'(sta_ff) << 14;
                  quo_ff <= '0;
                  dcnt_ff <= 4'd8;
                  if (start_trig) begin
                     in_event_ff <= 1'b1;
                     pk_foot_ff <= '0;
                     pk_veh_ff <= '0;
                  end else if (in_event_ff) begin
                     if (lta_ok ? (lhs512 < rhs) : (coef_ff[CSR_TRIGGER] != 16'd0)) begin
                        in_event_ff <= 1'b0;
                        hold_ff <= HoldLoad;
                     end
                  end
               end
               default: ;
            endcase
         end
         if (state_ff == ST_DIV) begin
            // restoring division, one quotient bit per cycle, MSB first
            if (trial != '0 && (trial >> dcnt_ff) == den_ff && rem_ff >= trial) begin
               rem_ff <= rem_ff - trial;
               quo_ff[dcnt_ff] <= 1'b1;
            end
            if (dcnt_ff != 4'd0) dcnt_ff <= dcnt_ff - 4'd1;
         end
         if (state_ff == ST_DONE && (!out_valid_ff || rsp.ready)) begin
            out_ff <= {trig_ff, cls_ff,
                       (!trig_ff) ? 8'd0 :
                       (coef_ff[CSR_TRIGGER] == 16'd0 || quo_ff[8]) ? 8'hFF : quo_ff[7:0],
                       pk_out_ff,
                       (lta_ff[AvgWidth-1:32] != '0) ? 16'hFFFF : lta_ff[31:16]};
         end
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.payload = out_ff;
endmodule
`default_nettype wire

// ----- tb/sv/tb_sta_lta_event_detector_unit.sv -----
// Testbench for the STA/LTA event detector: drives samples, predicts each result.
// Depends on sld_pkg, sld_stream_if and sta_lta_event_detector_unit.
`timescale 1ns / 1ps
module tb_sta_lta_event_detector_unit;
   import sld_pkg::*;

   localparam int HoldoffLen  = 500;
   localparam int EnergyAlpha = 262;
   localparam int SettleCycles = 300;

   typedef struct packed {
      logic             triggered;
      detect_class_type class_code;
      logic [7:0]       confidence;
      logic [15:0]      peak_level;
      logic [15:0]      noise_floor;
   } detection_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [CsrAddrWidth-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   sld_stream_if #(.Width(16)) req_if (clock);
   sld_stream_if #(.Width(43)) rsp_if (clock);

   sta_lta_event_detector_unit #(
      .HoldoffSamples(HoldoffLen),
      .EnergyCoef(EnergyAlpha)
   ) uut (
      .clock(clock), .reset(reset), .req(req_if.sink), .rsp(rsp_if.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #6 clock = ~clock;

   // detector model state
   logic [15:0] coef_reg [8];
   logic signed [39:0] in_hp, foot_hp, foot_lp, veh_hp, veh_lp;
   logic signed [15:0] prev_sample;
   logic [33:0] sta, lta, foot_nrg, foot_pk, veh_nrg, veh_pk;
   logic event_active;
   logic [15:0] holdoff_left;

   detection_type pending_detections[$];
   int mismatch_count = 0;
   int samples_sent = 0;
   int results_seen = 0;
   int triggers_seen = 0;
   int burst_left = 0;
   bit gaps_enabled = 1'b1;
   bit hold_request = 1'b0;

   function automatic logic signed [39:0] clamp40(input longint v);
      if (v > 64'sd549755813887) return 40'sh7FFFFFFFFF;
      if (v < -64'sd549755813888) return 40'sh8000000000;
      return v[39:0];
   endfunction

   function automatic logic [33:0] magnitude(input logic signed [39:0] v);
      longint m;
      m = (v < 0) ? -longint'(v) : longint'(v);
      if (m > 64'sd17179869183) return '1;
      return m[33:0];
   endfunction

   function automatic logic signed [39:0] highpass_step(input logic signed [39:0] y,
         input logic signed [15:0] x, input logic signed [15:0] xp, input logic [15:0] a);
      longint sum;
      sum = longint'(y) + (longint'(x) - longint'(xp)) * 65536;
      return clamp40((sum * (65536 - longint'(a))) >>> 16);
   endfunction

   function automatic logic signed [39:0] lowpass_step(input logic signed [39:0] y,
         input logic signed [39:0] x, input logic [15:0] a);
      return clamp40(longint'(y) + (((longint'(x) - longint'(y)) * longint'(a)) >>> 16));
   endfunction

   function automatic logic [33:0] smooth(input logic [33:0] avg, input logic [33:0] r,
         input logic [15:0] a);
      longint unsigned d;
      if (r >= avg) begin
         d = (longint'(r - avg) * a) >> 16;
         return avg + d[33:0];
      end
      d = (longint'(avg - r) * a + 65535) >> 16;
      return avg - d[33:0];
   endfunction

   task automatic reset_model();
      coef_reg[CSR_HIGHPASS] = 16'd813;   coef_reg[CSR_SHORT] = 16'd1311;
      coef_reg[CSR_LONG] = 16'd13;        coef_reg[CSR_TRIGGER] = 16'd768;
      coef_reg[CSR_FOOT_HP] = 16'd13161;  coef_reg[CSR_FOOT_LP] = 16'd32853;
      coef_reg[CSR_VEH_HP] = 16'd1607;    coef_reg[CSR_VEH_LP] = 16'd13161;
      in_hp = '0; foot_hp = '0; foot_lp = '0; veh_hp = '0; veh_lp = '0;
      prev_sample = '0; sta = '0; lta = '0;
      foot_nrg = '0; foot_pk = '0; veh_nrg = '0; veh_pk = '0;
      event_active = 1'b0; holdoff_left = '0;
   endtask

   function automatic detection_type detect(input logic signed [15:0] x);
      detection_type d;
      logic [33:0] r, br, pk;
      longint unsigned tr, lt_scaled, conf, nf;
      logic lta_ok, below;
      d = '{triggered: 1'b0, class_code: CLASS_UNKNOWN, confidence: '0,
            peak_level: '0, noise_floor: '0};
      tr = coef_reg[CSR_TRIGGER];
      in_hp = highpass_step(in_hp, x, prev_sample, coef_reg[CSR_HIGHPASS]);
      r = magnitude(in_hp);
      sta = smooth(sta, r, coef_reg[CSR_SHORT]);
      if (!event_active && holdoff_left == 0) lta = smooth(lta, r, coef_reg[CSR_LONG]);
      if (holdoff_left > 0) holdoff_left--;
      foot_hp = highpass_step(foot_hp, x, prev_sample, coef_reg[CSR_FOOT_HP]);
      foot_lp = lowpass_step(foot_lp, foot_hp, coef_reg[CSR_FOOT_LP]);
      br = magnitude(foot_lp);
      foot_nrg = smooth(foot_nrg, br, 16'(EnergyAlpha));
      if (br > foot_pk) foot_pk = br;
      veh_hp = highpass_step(veh_hp, x, prev_sample, coef_reg[CSR_VEH_HP]);
      veh_lp = lowpass_step(veh_lp, veh_hp, coef_reg[CSR_VEH_LP]);
      br = magnitude(veh_lp);
      veh_nrg = smooth(veh_nrg, br, 16'(EnergyAlpha));
      if (br > veh_pk) veh_pk = br;
      prev_sample = x;
      lta_ok = lta >= LtaMin;
      lt_scaled = tr * longint'(lta);
      if (!event_active && lta_ok && longint'(sta) * 256 >= lt_scaled) begin
         event_active = 1'b1;
         d.triggered = 1'b1;
         if (longint'(foot_nrg) > 2 * longint'(veh_nrg)) d.class_code = CLASS_FOOTSTEP;
         else if (longint'(veh_nrg) > 2 * longint'(foot_nrg)) d.class_code = CLASS_VEHICLE;
         else if (foot_nrg != 0 || veh_nrg != 0) d.class_code = CLASS_MULTIPLE;
         if (tr == 0) begin
            d.confidence = 8'd255;
         end else begin
            conf = (longint'(sta) * 16384) / lt_scaled;
            d.confidence = (conf > 255) ? 8'd255 : conf[7:0];
         end
         pk = (foot_pk > veh_pk) ? foot_pk : veh_pk;
         d.peak_level = (pk[33:16] > 18'd65535) ? 16'hFFFF : pk[31:16];
         foot_pk = '0;
         veh_pk = '0;
      end else if (event_active) begin
         below = lta_ok ? (longint'(sta) * 512 < lt_scaled) : (tr > 0);
         if (below) begin
            event_active = 1'b0;
            holdoff_left = 16'(HoldoffLen);
         end
      end
      nf = longint'(lta) >> 16;
      d.noise_floor = (nf > 65535) ? 16'hFFFF : nf[15:0];
      return d;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch on result %0d: %s got %0d expected %0d",
               results_seen, what, got, want);
      mismatch_count++;
   endtask

   // result checker
   always @(posedge clock) begin
      detection_type got, want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got = rsp_if.payload;
         if (pending_detections.size() == 0) begin
            report_mismatch("unexpected transaction", 1, 0);
         end else begin
            want = pending_detections.pop_front();
            if (got.triggered !== want.triggered)
               report_mismatch("triggered", got.triggered, want.triggered);
            if (got.class_code !== want.class_code)
               report_mismatch("class_code", got.class_code, want.class_code);
            if (got.confidence !== want.confidence)
               report_mismatch("confidence", got.confidence, want.confidence);
            if (got.peak_level !== want.peak_level)
               report_mismatch("peak_level", got.peak_level, want.peak_level);
            if (got.noise_floor !== want.noise_floor)
               report_mismatch("noise_floor", got.noise_floor, want.noise_floor);
            if (want.triggered) triggers_seen++;
         end
         results_seen++;
      end
   end

   // receiver: changing stall patterns, plus a long hold-off on request
   initial begin
      int mode, tick;
      rsp_if.ready = 1'b0;
      mode = 0;
      tick = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_if.ready = 1'b0;
            repeat (2000) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            tick++;
            if (tick % 500 == 0) mode = $urandom_range(0, 3);
            case (mode)
               0: rsp_if.ready = 1'b1;
               1: rsp_if.ready = 1'($urandom_range(0, 1));
               2: rsp_if.ready = (tick % 4 == 0);
               default: rsp_if.ready = ($urandom_range(0, 9) == 0);
            endcase
         end
      end
   end

   task automatic send_sample(input logic signed [15:0] x);
      int gap;
      @(negedge clock);
      req_if.valid = 1'b1;
      req_if.payload = x;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      pending_detections.push_back(detect(x));
      samples_sent++;
      if (gaps_enabled) begin
         if (burst_left == 0) begin
            gap = $urandom_range(1, 15);
            @(negedge clock);
            req_if.valid = 1'b0;
            repeat (gap - 1) @(negedge clock);
            burst_left = $urandom_range(1, 30);
         end else begin
            burst_left--;
         end
      end
   endtask

   // drain all results, then let the block settle before touching registers
   task automatic wait_idle();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (pending_detections.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [15:0] value);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_penable = 1'b0;
      csr_paddr = CsrAddrWidth'(idx) << 2;
      csr_pwdata = {16'h0, value};
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      if (csr_prdata !== {16'h0, value})
         report_mismatch("register readback", csr_prdata, value);
      coef_reg[idx] = value;
   endtask

   function automatic logic signed [15:0] noise(input int amp);
      return 16'($signed($urandom_range(0, 2 * amp)) - amp);
   endfunction

   // quiet background followed by a loud burst; now and then a lone spike
   task automatic send_events(input int count, input int quiet_amp);
      int sent, quiet_len, burst_len, burst_amp;
      sent = 0;
      while (sent < count) begin
         quiet_len = $urandom_range(15, 70);
         burst_len = $urandom_range(3, 40);
         burst_amp = ($urandom_range(0, 2) == 0) ? 32767 : $urandom_range(200, 8000);
         repeat (quiet_len) begin
            if (sent < count) begin
               if ($urandom_range(0, 30) == 0) send_sample(16'($urandom));
               else send_sample(noise(quiet_amp));
               sent++;
            end
         end
         repeat (burst_len) begin
            if (sent < count) begin
               send_sample(noise(burst_amp));
               sent++;
            end
         end
      end
   endtask

   task automatic test_directed();
      logic signed [15:0] edges [12];
      edges = '{16'sd0, 16'sd0, 16'sd1, -16'sd1, 16'sd32767, -16'sd32768, 16'sd32767,
                -16'sd32768, 16'sd0, 16'sd0, 16'sd100, -16'sd100};
      foreach (edges[i]) send_sample(edges[i]);
      repeat (6) send_sample(16'sd32767);
      repeat (6) send_sample(-16'sd32768);
   endtask

   task automatic test_default_coefs();
      send_events(300, 30);
      wait_idle();
   endtask

   task automatic test_fast_averages();
      write_reg(CSR_SHORT, 16'd6554);
      write_reg(CSR_LONG, 16'd655);
      write_reg(CSR_TRIGGER, 16'd512);
      write_reg(CSR_FOOT_HP, 16'd20000);
      write_reg(CSR_VEH_LP, 16'd3000);
      send_events(400, 50);
      wait_idle();
   endtask

   task automatic test_extreme_coefs();
      write_reg(CSR_HIGHPASS, 16'd0);
      write_reg(CSR_SHORT, 16'd65535);
      write_reg(CSR_LONG, 16'd65535);
      write_reg(CSR_TRIGGER, 16'd65535);
      write_reg(CSR_FOOT_HP, 16'd65535);
      write_reg(CSR_FOOT_LP, 16'd0);
      write_reg(CSR_VEH_HP, 16'd0);
      write_reg(CSR_VEH_LP, 16'd65535);
      send_events(250, 3000);
      wait_idle();
   endtask

   task automatic test_zero_ratio();
      write_reg(CSR_HIGHPASS, 16'd65535);
      write_reg(CSR_TRIGGER, 16'd0);
      write_reg(CSR_LONG, 16'd2000);
      write_reg(CSR_FOOT_LP, 16'd65535);
      write_reg(CSR_VEH_HP, 16'd65535);
      write_reg(CSR_VEH_LP, 16'd0);
      send_events(150, 200);
      wait_idle();
   endtask

   task automatic test_minimum_coefs();
      write_reg(CSR_HIGHPASS, 16'd813);
      write_reg(CSR_SHORT, 16'd1);
      write_reg(CSR_LONG, 16'd1);
      write_reg(CSR_TRIGGER, 16'd256);
      write_reg(CSR_FOOT_HP, 16'd0);
      send_events(200, 1000);
      wait_idle();
   endtask

   // receiver stops for a long stretch while samples keep coming
   task automatic test_backpressure();
      write_reg(CSR_SHORT, 16'd3000);
      write_reg(CSR_LONG, 16'd300);
      write_reg(CSR_TRIGGER, 16'd640);
      write_reg(CSR_FOOT_HP, 16'd13161);
      write_reg(CSR_FOOT_LP, 16'd32853);
      write_reg(CSR_VEH_HP, 16'd1607);
      write_reg(CSR_VEH_LP, 16'd13161);
      hold_request = 1'b1;
      send_events(250, 40);
      gaps_enabled = 1'b0;
      send_events(330, 40);
      wait_idle();
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.payload = '0;
      reset_model();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_default_coefs();
      test_fast_averages();
      test_extreme_coefs();
      test_zero_ratio();
      test_minimum_coefs();
      test_backpressure();
      $display("Ran %0d samples through %0d coefficient settings; %0d results checked,",
               samples_sent, 6, results_seen);
      $display("%0d of them event triggers, %0d field mismatches.",
               triggers_seen, mismatch_count);
      if (mismatch_count == 0 && pending_detections.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("timeout with %0d results outstanding", pending_detections.size());
      $display("FAILED: results differ");
      $finish;
   end
endmodule

// ----- sta_lta_event_detector_unit.f -----
rtl/sld_pkg.sv
rtl/sld_stream_if.sv
rtl/sld_serial_mac.sv
rtl/sta_lta_event_detector_unit.sv
tb/sv/tb_sta_lta_event_detector_unit.sv
